@@ rtl/rau_pkg.sv @@
// Package with the word types, operation codes and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    // Default operand width in bits.
    localparam int WIDTH_DEF = 32;

    // Operation codes.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    // Compare outcomes.
    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    // Input word.
    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] left_num;
        logic [30:0]        left_den;
        logic signed [31:0] right_num;
        logic [30:0]        right_den;
    } t_rau_in;

    // Result word.
    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         order;
        logic               div_zero;
        logic               overflow;
    } t_rau_out;

endpackage

`default_nettype wire

@@ rtl/rau_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rau_div #(
    parameter int MW = 63
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [MW-1:0] i_dividend,
    input  wire logic [MW-1:0] i_divisor,
    output logic               o_done,
    output logic [MW-1:0]      o_quot
);
    import rau_pkg::*;

    localparam int CW = $clog2(MW + 1);

    logic [MW:0]   r_rem;
    logic [MW-1:0] r_q;
    logic [MW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;
    logic [MW:0]   rem_sh;
    logic          fits;

    // Bring down the next dividend bit and try the subtraction.
    assign rem_sh = {r_rem[MW-1:0], r_q[MW-1]};
    assign fits   = rem_sh >= {1'b0, r_d};

    // Control: count the quotient bits down while running; done is flagged with the last bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(MW);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_run) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_d}) : rem_sh;
            r_q   <= {r_q[MW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

@@ rtl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: sequencer, shared multiplier and gcd datapath.
// Divide by zero and unused codes end after the first multiply state, compare after the sum;
// a zero result skips the gcd; otherwise a binary gcd loop reduces the result, followed by
// two bit-serial divisions (numerator, then denominator) on one divider.
// Throughput: one word at a time; o_busy stays high until the result strobe.
// Reset: i_rst_n is synchronous and active low; it returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire rau_pkg::t_rau_in  i_op,
    output logic                   o_busy,
    output logic                   o_valid,
    output rau_pkg::t_rau_out      o_res
);
    import rau_pkg::*;

    localparam int MW = 2 * WIDTH - 1;
    localparam int KW = $clog2(MW);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL0 = 4'd1;
    localparam logic [3:0] ST_MUL1 = 4'd2;
    localparam logic [3:0] ST_MUL2 = 4'd3;
    localparam logic [3:0] ST_SUM  = 4'd4;
    localparam logic [3:0] ST_CHK  = 4'd5;
    localparam logic [3:0] ST_GCD  = 4'd6;
    localparam logic [3:0] ST_GSH  = 4'd7;
    localparam logic [3:0] ST_DIVN = 4'd8;
    localparam logic [3:0] ST_DIVD = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [2:0]       r_func;
    logic             r_lneg, r_rneg;
    logic [WIDTH-1:0] r_lmag, r_rmag;
    logic [WIDTH-2:0] r_ld, r_rd;
    logic [MW-1:0]    r_x, r_y, r_t, r_ga, r_gb, r_g;
    logic             r_neg;
    logic [KW-1:0]    r_k;
    logic             r_valid;
    t_rau_out         r_res;

    logic [WIDTH-1:0] in_lv, in_rv, in_lmag, in_rmag;
    logic [WIDTH-2:0] in_ld, in_rd;
    logic [WIDTH-1:0] m_a, m_b;
    logic [2*WIDTH-1:0] prod;
    logic             is_addc, bad_op, dz;
    logic             b_neg;
    logic [MW-1:0]    sum_mag;
    logic             sum_neg;
    logic             gcd_end;
    logic             div_start, div_done;
    logic [MW-1:0]    div_dvd, div_quot;
    logic [MW-1:0]    half;
    logic             ovf;
    logic signed [WIDTH-1:0] n_w;

    // Operand conditioning: sign-magnitude numerators, zero denominators read as one.
    assign in_lv   = i_op.left_num[WIDTH-1:0];
    assign in_rv   = i_op.right_num[WIDTH-1:0];
    assign in_lmag = in_lv[WIDTH-1] ? (~in_lv + 1'b1) : in_lv;
    assign in_rmag = in_rv[WIDTH-1] ? (~in_rv + 1'b1) : in_rv;
    assign in_ld   = (i_op.left_den[WIDTH-2:0] == '0) ? (WIDTH-1)'(1)
                                                      : i_op.left_den[WIDTH-2:0];
    assign in_rd   = (i_op.right_den[WIDTH-2:0] == '0) ? (WIDTH-1)'(1)
                                                       : i_op.right_den[WIDTH-2:0];

    assign is_addc = (r_func == OP_ADD) || (r_func == OP_SUB) || (r_func == OP_CMP);
    assign bad_op  = !is_addc && (r_func != OP_MUL) && (r_func != OP_DIV);
    assign dz      = (r_func == OP_DIV) && (r_rmag == '0);

    // Shared multiplier operand selection, one product per cycle.
    always_comb begin
        m_a = r_lmag;
        m_b = {1'b0, r_rd};
        case (r_state)
            ST_MUL0: begin
                if (r_func == OP_MUL) begin
                    m_b = r_rmag;
                end
            end
            ST_MUL1: begin
                if (is_addc) begin
                    m_a = r_rmag;
                    m_b = {1'b0, r_ld};
                end else if (r_func == OP_DIV) begin
                    m_a = {1'b0, r_ld};
                    m_b = r_rmag;
                end else begin
                    m_a = {1'b0, r_ld};
                    m_b = {1'b0, r_rd};
                end
            end
            ST_MUL2: begin
                m_a = {1'b0, r_ld};
                m_b = {1'b0, r_rd};
            end
            default: begin
                m_a = r_lmag;
                m_b = {1'b0, r_rd};
            end
        endcase
    end
    assign prod = m_a * m_b;

    // Signed sum of the two cross products (right term negated for subtract and compare).
    assign b_neg = r_rneg ^ (r_func != OP_ADD);
    always_comb begin
        if (r_lneg == b_neg) begin
            sum_mag = r_x + r_t;
            sum_neg = r_lneg;
        end else if (r_x >= r_t) begin
            sum_mag = r_x - r_t;
            sum_neg = r_lneg;
        end else begin
            sum_mag = r_t - r_x;
            sum_neg = b_neg;
        end
    end

    assign gcd_end = r_ga[0] && r_gb[0] && (r_ga == r_gb);

    // Shared divider: numerator first, then denominator.
    assign div_start = (r_state == ST_GSH) || ((r_state == ST_DIVN) && div_done);
    assign div_dvd   = (r_state == ST_GSH) ? r_x : r_y;

    rau_div #(
        .MW(MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_g),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Range check of the reduced result.
    assign half = MW'(1) << (WIDTH - 1);
    assign ovf  = ((r_y >> (WIDTH - 1)) != '0) || (r_neg ? (r_x > half) : (r_x > half - 1'b1));
    assign n_w  = r_neg ? (~r_x[WIDTH-1:0] + 1'b1) : r_x[WIDTH-1:0];

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_MUL0;
                end
            end
            ST_MUL0: n_state = (bad_op || dz) ? ST_IDLE : ST_MUL1;
            ST_MUL1: n_state = is_addc ? ST_MUL2 : ST_CHK;
            ST_MUL2: n_state = ST_SUM;
            ST_SUM:  n_state = (r_func == OP_CMP) ? ST_IDLE : ST_CHK;
            ST_CHK:  n_state = (r_x == '0) ? ST_IDLE : ST_GCD;
            ST_GCD: begin
                if (gcd_end) begin
                    n_state = ST_GSH;
                end
            end
            ST_GSH:  n_state = ST_DIVN;
            ST_DIVN: begin
                if (div_done) begin
                    n_state = ST_DIVD;
                end
            end
            ST_DIVD: begin
                if (div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= ((r_state == ST_MUL0) && (bad_op || dz))
                    || ((r_state == ST_SUM) && (r_func == OP_CMP))
                    || ((r_state == ST_CHK) && (r_x == '0))
                    || (r_state == ST_FIN);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_func <= i_op.func;
                r_lneg <= in_lv[WIDTH-1];
                r_rneg <= in_rv[WIDTH-1];
                r_lmag <= in_lmag;
                r_rmag <= in_rmag;
                r_ld   <= in_ld;
                r_rd   <= in_rd;
            end
            ST_MUL0: begin
                r_x   <= prod[MW-1:0];
                r_neg <= r_lneg ^ r_rneg;
                r_res <= '{res_num: '0, res_den: 31'd1, order: ORD_LESS,
                           div_zero: dz, overflow: 1'b0};
            end
            ST_MUL1: begin
                if (is_addc) begin
                    r_t <= prod[MW-1:0];
                end else begin
                    r_y <= prod[MW-1:0];
                end
            end
            ST_MUL2: begin
                r_y <= prod[MW-1:0];
            end
            ST_SUM: begin
                r_x   <= sum_mag;
                r_neg <= sum_neg;
                r_res <= '{res_num: '0, res_den: 31'd1,
                           order: (sum_mag == '0) ? ORD_EQUAL
                                : (sum_neg ? ORD_LESS : ORD_GREATER),
                           div_zero: 1'b0, overflow: 1'b0};
            end
            ST_CHK: begin
                r_ga  <= r_x;
                r_gb  <= r_y;
                r_k   <= '0;
                r_res <= '{res_num: '0, res_den: 31'd1, order: ORD_LESS,
                           div_zero: 1'b0, overflow: 1'b0};
            end
            ST_GCD: begin
                // Binary gcd: strip common and single factors of two, subtract odd values.
                if (!r_ga[0] && !r_gb[0]) begin
                    r_ga <= r_ga >> 1;
                    r_gb <= r_gb >> 1;
                    r_k  <= r_k + 1'b1;
                end else if (!r_ga[0]) begin
                    r_ga <= r_ga >> 1;
                end else if (!r_gb[0]) begin
                    r_gb <= r_gb >> 1;
                end else if (r_ga == r_gb) begin
                    r_g <= r_ga << r_k;
                end else if (r_ga > r_gb) begin
                    r_ga <= (r_ga - r_gb) >> 1;
                end else begin
                    r_gb <= (r_gb - r_ga) >> 1;
                end
            end
            ST_DIVN: begin
                if (div_done) begin
                    r_x <= div_quot;
                end
            end
            ST_DIVD: begin
                if (div_done) begin
                    r_y <= div_quot;
                end
            end
            ST_FIN: begin
                if (ovf) begin
                    r_res <= '{res_num: '0, res_den: 31'd1, order: ORD_LESS,
                               div_zero: 1'b0, overflow: 1'b1};
                end else begin
                    r_res <= '{res_num: 32'(n_w), res_den: 31'(r_y[WIDTH-2:0]),
                               order: ORD_LESS, div_zero: 1'b0, overflow: 1'b0};
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // The result strobe only appears once the sequencer is back in idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("result strobe while busy");

    // An accepted word always holds the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_valid)) else $error("accepted word not held");

    // Flags are exclusive and a flagged result carries zero over one.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.div_zero || o_res.overflow)) |->
        (!(o_res.div_zero && o_res.overflow) && o_res.res_num == 0 && o_res.res_den == 1))
        else $error("flagged result not cleared");

    // The denominator of a result is never zero.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.res_den != 0)) else $error("zero result denominator");

endmodule

`default_nettype wire

@@ verif/rational_arithmetic_unit_tb.sv @@
// Self-checking testbench for the rational arithmetic unit: directed and random words.
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int NB = 32;
    localparam logic [63:0] HALF_MAG = 64'h8000_0000;
    localparam logic [63:0] DEN_MAX  = 64'h7FFF_FFFF;

    // Sign-magnitude value at double width.
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_smag;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_start;
    t_rau_in  i_op;
    logic     o_busy;
    logic     o_valid;
    t_rau_out o_res;

    t_rau_out pending_results[$];
    int       error_count;
    int       send_idle_pct;

    rational_arithmetic_unit #(.WIDTH(NB)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_op),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_smag split_num(logic [31:0] raw);
        t_smag r;
        r.neg = raw[31];
        r.mag = raw[31] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
        return r;
    endfunction

    function automatic logic [63:0] clean_den(logic [30:0] raw);
        return (raw == 31'd0) ? 64'd1 : {33'd0, raw};
    endfunction

    function automatic logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 64'd0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_smag signed_sum(t_smag x, t_smag y);
        t_smag r;
        if (x.neg == y.neg) begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end else if (x.mag >= y.mag) begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end else begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        if (r.mag == 64'd0) r.neg = 1'b0;
        return r;
    endfunction

    // Exact rational result of one word, reduced and range-checked.
    function automatic t_rau_out rational_result(t_rau_in w);
        t_smag       ln, rn, a, b, num;
        logic [63:0] ld, rd, den, g;
        logic        have;
        t_rau_out    r;
        ln = split_num(w.left_num);
        rn = split_num(w.right_num);
        ld = clean_den(w.left_den);
        rd = clean_den(w.right_den);
        r = '0;
        r.res_den = 31'd1;
        r.order = ORD_LESS;
        num = '0;
        den = 64'd1;
        have = 1'b1;
        case (w.func)
            OP_ADD, OP_SUB, OP_CMP: begin
                a.neg = ln.neg;
                a.mag = ln.mag * rd;
                b.neg = rn.neg;
                b.mag = rn.mag * ld;
                if (w.func != OP_ADD && b.mag != 64'd0) b.neg = ~b.neg;
                num = signed_sum(a, b);
                den = ld * rd;
                if (w.func == OP_CMP) begin
                    r.order = (num.mag == 64'd0) ? ORD_EQUAL :
                              (num.neg ? ORD_LESS : ORD_GREATER);
                    have = 1'b0;
                end
            end
            OP_MUL: begin
                num.mag = ln.mag * rn.mag;
                num.neg = (num.mag != 64'd0) && (ln.neg != rn.neg);
                den = ld * rd;
            end
            OP_DIV: begin
                if (rn.mag == 64'd0) begin
                    r.div_zero = 1'b1;
                    have = 1'b0;
                end else begin
                    num.mag = ln.mag * rd;
                    num.neg = (num.mag != 64'd0) && (ln.neg != rn.neg);
                    den = ld * rn.mag;
                end
            end
            default: have = 1'b0;
        endcase
        if (have) begin
            g = euclid(num.mag, den);
            if (g == 64'd0) g = 64'd1;
            num.mag = num.mag / g;
            den = den / g;
            if (num.mag == 64'd0) den = 64'd1;
            if (den > DEN_MAX || (num.neg ? num.mag > HALF_MAG : num.mag > HALF_MAG - 1))
                r.overflow = 1'b1;
            else begin
                r.res_num = num.neg ? (32'd0 - num.mag[31:0]) : num.mag[31:0];
                r.res_den = den[30:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Send one word, with a random idle gap before it.
    task automatic send_word(t_rau_in w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_op    <= w;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_results.push_back(rational_result(w));
        @(negedge i_clk);
    endtask

    task automatic send_op(logic [2:0] f, logic [31:0] ln, logic [30:0] ld,
                           logic [31:0] rn, logic [30:0] rd);
        t_rau_in w;
        w.func = f;
        w.left_num = ln;
        w.left_den = ld;
        w.right_num = rn;
        w.right_den = rd;
        send_word(w);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Check each result against the oldest expectation.
    always @(posedge i_clk) begin
        t_rau_out want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", o_res.res_num, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_res.res_num !== want.res_num)
                    report_mismatch("res_num", o_res.res_num, want.res_num);
                if (o_res.res_den !== want.res_den)
                    report_mismatch("res_den", 32'(o_res.res_den), 32'(want.res_den));
                if (o_res.order !== want.order)
                    report_mismatch("order", 32'(o_res.order), 32'(want.order));
                if (o_res.div_zero !== want.div_zero)
                    report_mismatch("div_zero", 32'(o_res.div_zero), 32'(want.div_zero));
                if (o_res.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_res.overflow), 32'(want.overflow));
            end
        end
    end

    // Field extremes, every operation and each named special case.
    task automatic test_directed();
        send_op(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
        send_op(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
        send_op(OP_MUL, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1);
        send_op(OP_MUL, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFE);
        send_op(OP_DIV, 32'd3, 31'd4, 32'd0, 31'd5);
        send_op(OP_DIV, 32'hFFFF_FFFA, 31'd7, 32'hFFFF_FFFD, 31'd14);
        send_op(OP_CMP, 32'd1, 31'd3, 32'd2, 31'd6);
        send_op(OP_CMP, 32'hFFFF_FFFF, 31'd2, 32'd1, 31'd2);
        send_op(OP_CMP, 32'd5, 31'd1, 32'd4, 31'd1);
        send_op(OP_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);
        send_op(OP_SUB, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
        send_op(OP_ADD, 32'd1, 31'd0, 32'd1, 31'd0);
        send_op(OP_ADD, 32'd2, 31'd4, 32'd6, 31'd8);
        send_op(OP_MUL, 32'd0, 31'h7FFF_FFFF, 32'd9, 31'd3);
        send_op(3'd5, 32'd1, 31'd1, 32'd1, 31'd1);
        send_op(3'd6, 32'h8000_0000, 31'd0, 32'h7FFF_FFFF, 31'd0);
        send_op(3'd7, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'd0, 31'd1);
        send_op(OP_DIV, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1);
        send_op(OP_ADD, 32'd1, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFE);
        send_op(OP_SUB, 32'hFFFF_FFFF, 31'h5555_5555, 32'h0000_0001, 31'h2AAA_AAAA);
    endtask

    function automatic logic [31:0] pick_num();
        case ($urandom_range(5))
            0: return $urandom_range(20) - 10;
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return 32'h7FFF_FFFF - $urandom_range(3);
            3: return $urandom_range(1000) - 500;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(5))
            0: return 31'($urandom_range(12));
            1: return 31'(32'h7FFF_FFFF - $urandom_range(3));
            2: return 31'($urandom_range(1000));
            default: return 31'($urandom);
        endcase
    endfunction

    // Random words, mostly valid operations with a few unused codes.
    task automatic test_random(int count);
        logic [2:0] f;
        for (int i = 0; i < count; i++) begin
            f = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            send_op(f, pick_num(), pick_den(), pick_num(), pick_den());
        end
    endtask

    // Hold off the sender until every result has come back, then pause and send one divide.
    task automatic test_drain_pause();
        wait_drained();
        repeat (20) @(negedge i_clk);
        send_op(OP_DIV, 32'd7, 31'd9, 32'hFFFF_FFF9, 31'd3);
    endtask

    initial begin
        error_count = 0;
        send_idle_pct = 29;
        i_start = 1'b0;
        i_op = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(130);
        test_drain_pause();
        send_idle_pct = 46;
        test_random(130);
        send_idle_pct = 0;
        test_random(130);

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("rational_arithmetic_unit_tb: clean");
        else
            $display("rational_arithmetic_unit_tb: errors");
        $finish;
    end

    // Run limit.
    initial begin
        #5ms;
        $display("rational_arithmetic_unit_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rau_pkg.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit.sv
verif/rational_arithmetic_unit_tb.sv
